[rtl/hrb_pkg.sv]
// Shared types and constants for the HID report builder.
package hrb_pkg;

  localparam int KEY_SLOTS_DEF      = 6;
  localparam int CONSUMER_SLOTS_DEF = 4;

  localparam logic [7:0] REPORT_ID_KEYBOARD = 8'd1;
  localparam logic [7:0] REPORT_ID_MOUSE    = 8'd2;
  localparam logic [7:0] REPORT_ID_CONSUMER = 8'd3;
  localparam logic [7:0] BYTE_MASK          = 8'hFF;

  localparam logic [15:0] PROTO_BOOT   = 16'd0;
  localparam logic [15:0] PROTO_REPORT = 16'd1;

  typedef enum logic [3:0] {
    MODE_KEYPRESS    = 4'd0,
    MODE_KEYRELEASE  = 4'd1,
    MODE_KEYCLEARALL = 4'd2,
    MODE_MOVE        = 4'd3,
    MODE_BTNPRESS    = 4'd4,
    MODE_BTNRELEASE  = 4'd5,
    MODE_SCROLL      = 4'd6,
    MODE_CONSPRESS   = 4'd7,
    MODE_CONSRELEASE = 4'd8,
    MODE_CONSCLEAR   = 4'd9,
    MODE_WAKE        = 4'd10,
    MODE_SUSPEND     = 4'd11,
    MODE_SETPROTO    = 4'd12,
    MODE_LED         = 4'd13,
    MODE_CONFIGURE   = 4'd14
  } mode_t;

  typedef struct packed {
    logic latch;   // capture the incoming request
    logic apply;   // update report state from the captured request
    logic load;    // move the current report byte into the output register
  } hrb_cmd_t;

  typedef struct packed {
    logic emits;     // captured request produces a report
    logic is_last;   // current byte is the final one of the report
    logic out_free;  // output register can take a byte this cycle
  } hrb_sts_t;

endpackage

[rtl/hrb_in_if.sv]
// Event request channel.
interface hrb_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  mode;
  logic [15:0] code;
  logic signed [7:0] move_x;
  logic signed [7:0] move_y;
  logic signed [7:0] wheel_delta;

  modport source (output valid, mode, code, move_x, move_y, wheel_delta, input ready);
  modport sink   (input valid, mode, code, move_x, move_y, wheel_delta, output ready);
endinterface

[rtl/hrb_out_if.sv]
// Report byte channel.
interface hrb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] report_byte;
  logic       last;
  logic       sent_ok;
  logic [7:0] led_bits;
  logic       link_up;

  modport source (output valid, report_byte, last, sent_ok, led_bits, link_up, input ready);
  modport sink   (input valid, report_byte, last, sent_ok, led_bits, link_up, output ready);
endinterface

[rtl/hrb_ctrl.sv]
// Sequencer: capture request, apply state update, stream report bytes.
module hrb_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  hrb_pkg::hrb_sts_t sts,
  output hrb_pkg::hrb_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_APPLY,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, in_ready_nxt;

  always_comb begin
    state_nxt    = state_r;
    in_ready_nxt = in_ready_r;
    cmd          = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.latch    = 1'b1;
          state_nxt    = S_APPLY;
          in_ready_nxt = 1'b0;
        end
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        if (sts.emits) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt    = S_IDLE;
          in_ready_nxt = 1'b1;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.load = 1'b1;
          if (sts.is_last) begin
            state_nxt    = S_IDLE;
            in_ready_nxt = 1'b1;
          end
        end
      end
      default: begin
        state_nxt    = S_IDLE;
        in_ready_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= in_ready_nxt;
    end
  end

  assign in_ready = in_ready_r;

endmodule

[rtl/hrb_dp.sv]
// Report state, slot search, byte serializer and output register.
module hrb_dp #(
  parameter int KEY_SLOTS      = hrb_pkg::KEY_SLOTS_DEF,
  parameter int CONSUMER_SLOTS = hrb_pkg::CONSUMER_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  hrb_pkg::hrb_cmd_t cmd,
  output hrb_pkg::hrb_sts_t sts,
  hrb_in_if.sink            in_ch,
  hrb_out_if.source         out_ch
);

  localparam int KB_LEN    = 3 + KEY_SLOTS;
  localparam int CON_LEN   = 1 + 2 * CONSUMER_SLOTS;
  localparam int MOUSE_LEN = 5;
  localparam int KC_LEN    = (KB_LEN > CON_LEN) ? KB_LEN : CON_LEN;
  localparam int MAX_LEN   = (KC_LEN > MOUSE_LEN) ? KC_LEN : MOUSE_LEN;
  localparam int IW        = $clog2(MAX_LEN);
  localparam int JW        = IW + 1;

  // captured request
  hrb_pkg::mode_t ev_mode_r;
  logic [15:0]    ev_code_r;
  logic [7:0]     ev_x_r, ev_y_r, ev_w_r;

  // report state
  logic [7:0]  key_r [KEY_SLOTS];
  logic [7:0]  key_nxt [KEY_SLOTS];
  logic [15:0] cons_r [CONSUMER_SLOTS];
  logic [15:0] cons_nxt [CONSUMER_SLOTS];
  logic [7:0]  mods_r, mods_nxt;
  logic [7:0]  btns_r, btns_nxt;
  logic [7:0]  led_r, led_nxt;
  logic        conn_r, conn_nxt;
  logic        boot_r, boot_nxt;

  // serializer
  logic [IW-1:0] idx_r;
  logic [IW-1:0] last_idx;
  logic [JW-1:0] kb_pos;
  logic [7:0]    byte_cur;
  logic          is_kb, is_mouse, refused;

  // output register
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r, out_ok_r, out_link_r;
  logic [7:0] out_led_r;

  logic [7:0] usage, mods_in;
  logic       hit;

  assign usage   = ev_code_r[7:0];
  assign mods_in = ev_code_r[15:8];

  always_comb begin
    key_nxt  = key_r;
    cons_nxt = cons_r;
    mods_nxt = mods_r;
    btns_nxt = btns_r;
    led_nxt  = led_r;
    conn_nxt = conn_r;
    boot_nxt = boot_r;
    hit      = 1'b0;
    unique case (ev_mode_r)
      hrb_pkg::MODE_KEYPRESS: begin
        for (int i = 0; i < KEY_SLOTS; i++) begin
          if (!hit && key_r[i] == 8'd0) begin
            key_nxt[i] = usage;
            hit        = 1'b1;
          end
        end
        mods_nxt = mods_r | mods_in;
      end
      hrb_pkg::MODE_KEYRELEASE: begin
        for (int i = 0; i < KEY_SLOTS; i++) begin
          if (!hit && key_r[i] == usage) begin
            key_nxt[i] = 8'd0;
            hit        = 1'b1;
          end
        end
        mods_nxt = mods_r & ~mods_in;
      end
      hrb_pkg::MODE_KEYCLEARALL: begin
        for (int i = 0; i < KEY_SLOTS; i++) key_nxt[i] = 8'd0;
        mods_nxt = 8'd0;
      end
      hrb_pkg::MODE_BTNPRESS:   btns_nxt = btns_r | usage;
      hrb_pkg::MODE_BTNRELEASE: btns_nxt = btns_r & ~usage;
      hrb_pkg::MODE_CONSPRESS: begin
        for (int i = 0; i < CONSUMER_SLOTS; i++) begin
          if (!hit && cons_r[i] == 16'd0) begin
            cons_nxt[i] = ev_code_r;
            hit         = 1'b1;
          end
        end
      end
      hrb_pkg::MODE_CONSRELEASE: begin
        for (int i = 0; i < CONSUMER_SLOTS; i++) begin
          if (!hit && cons_r[i] == ev_code_r) begin
            cons_nxt[i] = 16'd0;
            hit         = 1'b1;
          end
        end
      end
      hrb_pkg::MODE_CONSCLEAR: begin
        for (int i = 0; i < CONSUMER_SLOTS; i++) cons_nxt[i] = 16'd0;
      end
      hrb_pkg::MODE_WAKE:    conn_nxt = 1'b1;
      hrb_pkg::MODE_SUSPEND: conn_nxt = 1'b0;
      hrb_pkg::MODE_SETPROTO: begin
        if (ev_code_r == hrb_pkg::PROTO_BOOT) begin
          boot_nxt = 1'b1;
        end else if (ev_code_r == hrb_pkg::PROTO_REPORT) begin
          boot_nxt = 1'b0;
        end
      end
      hrb_pkg::MODE_LED:       led_nxt  = usage;
      hrb_pkg::MODE_CONFIGURE: boot_nxt = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KEY_SLOTS; i++) key_r[i] <= 8'd0;
      for (int i = 0; i < CONSUMER_SLOTS; i++) cons_r[i] <= 16'd0;
      mods_r <= 8'd0;
      btns_r <= 8'd0;
      led_r  <= 8'd0;
      conn_r <= 1'b0;
      boot_r <= 1'b0;
    end else if (cmd.apply) begin
      key_r  <= key_nxt;
      cons_r <= cons_nxt;
      mods_r <= mods_nxt;
      btns_r <= btns_nxt;
      led_r  <= led_nxt;
      conn_r <= conn_nxt;
      boot_r <= boot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      ev_mode_r <= hrb_pkg::mode_t'(in_ch.mode);
      ev_code_r <= in_ch.code;
      ev_x_r    <= in_ch.move_x;
      ev_y_r    <= in_ch.move_y;
      ev_w_r    <= in_ch.wheel_delta;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      idx_r <= '0;
    end else if (cmd.load) begin
      idx_r <= idx_r + IW'(1);
    end
  end

  assign is_kb    = (ev_mode_r <= hrb_pkg::MODE_KEYCLEARALL);
  assign is_mouse = !is_kb && (ev_mode_r <= hrb_pkg::MODE_SCROLL);
  assign refused  = !conn_r || (boot_r && !is_kb);
  assign kb_pos   = boot_r ? ({1'b0, idx_r} + JW'(1)) : {1'b0, idx_r};

  always_comb begin
    if (refused) begin
      last_idx = '0;
    end else if (is_kb) begin
      last_idx = boot_r ? IW'(KEY_SLOTS + 1) : IW'(KEY_SLOTS + 2);
    end else if (is_mouse) begin
      last_idx = IW'(MOUSE_LEN - 1);
    end else begin
      last_idx = IW'(2 * CONSUMER_SLOTS);
    end
  end

  always_comb begin
    byte_cur = 8'd0;
    if (refused) begin
      byte_cur = 8'd0;
    end else if (is_kb) begin
      if (kb_pos == JW'(0)) byte_cur = hrb_pkg::REPORT_ID_KEYBOARD;
      if (kb_pos == JW'(1)) byte_cur = mods_r;
      for (int k = 0; k < KEY_SLOTS; k++) begin
        if (kb_pos == JW'(k + 3)) byte_cur = key_r[k];
      end
    end else if (is_mouse) begin
      case (idx_r)
        IW'(0): byte_cur = hrb_pkg::REPORT_ID_MOUSE;
        IW'(1): byte_cur = btns_r;
        IW'(2): byte_cur = (ev_mode_r == hrb_pkg::MODE_MOVE) ? ev_x_r : 8'd0;
        IW'(3): byte_cur = (ev_mode_r == hrb_pkg::MODE_MOVE) ? ev_y_r : 8'd0;
        IW'(4): byte_cur = (ev_mode_r == hrb_pkg::MODE_SCROLL) ? ev_w_r : 8'd0;
        default: byte_cur = 8'd0;
      endcase
    end else begin
      if (idx_r == IW'(0)) byte_cur = hrb_pkg::REPORT_ID_CONSUMER;
      for (int k = 0; k < CONSUMER_SLOTS; k++) begin
        if (idx_r == IW'(2 * k + 1)) byte_cur = cons_r[k][7:0] & hrb_pkg::BYTE_MASK;
        if (idx_r == IW'(2 * k + 2)) byte_cur = cons_r[k][15:8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_byte_r <= byte_cur;
      out_last_r <= (idx_r == last_idx);
      out_ok_r   <= !refused;
      out_led_r  <= led_r;
      out_link_r <= conn_r;
    end
  end

  assign sts.emits    = (ev_mode_r <= hrb_pkg::MODE_CONSCLEAR);
  assign sts.is_last  = (idx_r == last_idx);
  assign sts.out_free = !out_valid_r || out_ch.ready;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.report_byte = out_byte_r;
  assign out_ch.last        = out_last_r;
  assign out_ch.sent_ok     = out_ok_r;
  assign out_ch.led_bits    = out_led_r;
  assign out_ch.link_up     = out_link_r;

endmodule

[rtl/hid_report_builder_top.sv]
// HID report builder top level.
// Takes one keyboard, mouse, consumer or status event per request and keeps
// the combined report state; every report event streams its report one byte
// per transfer on the output channel (or a single refused marker when the link
// is down or boot protocol blocks the report). An event is first captured and
// then updates the state; a report of N bytes then leaves at one byte per
// cycle while the output register can take a byte, with N up to
// max(5, 3 + KEY_SLOTS, 1 + 2 * CONSUMER_SLOTS), and a status event ends
// after the state update. The next event is taken while the final byte still
// sits in the output register.
module hid_report_builder_top #(
  parameter int KEY_SLOTS      = hrb_pkg::KEY_SLOTS_DEF,
  parameter int CONSUMER_SLOTS = hrb_pkg::CONSUMER_SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  hrb_in_if.sink    in_ch,
  hrb_out_if.source out_ch
);

  hrb_pkg::hrb_cmd_t cmd;
  hrb_pkg::hrb_sts_t sts;

  hrb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hrb_dp #(
    .KEY_SLOTS      (KEY_SLOTS),
    .CONSUMER_SLOTS (CONSUMER_SLOTS)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .sts    (sts),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

[verif/hid_report_builder_top_tb.sv]
// Self-checking testbench for hid_report_builder_top with a report-state predictor.

typedef struct packed {
  logic [7:0] report_byte;
  logic       last;
  logic       sent_ok;
  logic [7:0] led_bits;
  logic       link_up;
} hid_byte_t;

class hid_report_predictor;
  localparam int NKEY  = hrb_pkg::KEY_SLOTS_DEF;
  localparam int NCONS = hrb_pkg::CONSUMER_SLOTS_DEF;

  logic [7:0]  keys [NKEY];
  logic [15:0] cons [NCONS];
  logic [7:0]  mods;
  logic [7:0]  buttons;
  logic [7:0]  leds;
  logic        link;
  logic        boot;

  hid_byte_t pending_bytes[$];
  int errors;
  int checked;
  int refused;
  int requests;

  function new();
    foreach (keys[i]) keys[i] = '0;
    foreach (cons[i]) cons[i] = '0;
    mods = '0;
    buttons = '0;
    leds = '0;
    link = 1'b0;
    boot = 1'b0;
    errors = 0;
    checked = 0;
    refused = 0;
    requests = 0;
  endfunction

  function void push_byte(logic [7:0] b, logic is_last, logic ok);
    hid_byte_t e;
    e.report_byte = b;
    e.last = is_last;
    e.sent_ok = ok;
    e.led_bits = leds;
    e.link_up = link;
    pending_bytes.push_back(e);
  endfunction

  function void emit_report(logic [7:0] rid, logic [7:0] mx, logic [7:0] my,
                            logic [7:0] wh);
    logic [7:0] bytes[$];
    if (!link || (boot && rid != hrb_pkg::REPORT_ID_KEYBOARD)) begin
      push_byte(8'h00, 1'b1, 1'b0);
      refused++;
      return;
    end
    if (rid == hrb_pkg::REPORT_ID_KEYBOARD) begin
      if (!boot) bytes.push_back(hrb_pkg::REPORT_ID_KEYBOARD);
      bytes.push_back(mods);
      bytes.push_back(8'h00);
      foreach (keys[i]) bytes.push_back(keys[i]);
    end else if (rid == hrb_pkg::REPORT_ID_MOUSE) begin
      bytes.push_back(hrb_pkg::REPORT_ID_MOUSE);
      bytes.push_back(buttons);
      bytes.push_back(mx);
      bytes.push_back(my);
      bytes.push_back(wh);
    end else begin
      bytes.push_back(hrb_pkg::REPORT_ID_CONSUMER);
      foreach (cons[i]) begin
        bytes.push_back(cons[i][7:0]);
        bytes.push_back(cons[i][15:8]);
      end
    end
    foreach (bytes[i]) push_byte(bytes[i], i == bytes.size() - 1, 1'b1);
  endfunction

  function void apply_request(logic [3:0] mode, logic [15:0] code, logic [7:0] mx,
                              logic [7:0] my, logic [7:0] wh);
    logic [7:0] usage;
    logic [7:0] kmods;
    bit done;
    usage = code[7:0];
    kmods = code[15:8];
    done = 0;
    requests++;
    case (mode)
      hrb_pkg::MODE_KEYPRESS: begin
        foreach (keys[i])
          if (!done && keys[i] == 8'h00) begin
            keys[i] = usage;
            done = 1;
          end
        mods = mods | kmods;
        emit_report(hrb_pkg::REPORT_ID_KEYBOARD, 8'h00, 8'h00, 8'h00);
      end
      hrb_pkg::MODE_KEYRELEASE: begin
        foreach (keys[i])
          if (!done && keys[i] == usage) begin
            keys[i] = 8'h00;
            done = 1;
          end
        mods = mods & ~kmods;
        emit_report(hrb_pkg::REPORT_ID_KEYBOARD, 8'h00, 8'h00, 8'h00);
      end
      hrb_pkg::MODE_KEYCLEARALL: begin
        foreach (keys[i]) keys[i] = 8'h00;
        mods = 8'h00;
        emit_report(hrb_pkg::REPORT_ID_KEYBOARD, 8'h00, 8'h00, 8'h00);
      end
      hrb_pkg::MODE_MOVE: emit_report(hrb_pkg::REPORT_ID_MOUSE, mx, my, 8'h00);
      hrb_pkg::MODE_BTNPRESS: begin
        buttons = buttons | usage;
        emit_report(hrb_pkg::REPORT_ID_MOUSE, 8'h00, 8'h00, 8'h00);
      end
      hrb_pkg::MODE_BTNRELEASE: begin
        buttons = buttons & ~usage;
        emit_report(hrb_pkg::REPORT_ID_MOUSE, 8'h00, 8'h00, 8'h00);
      end
      hrb_pkg::MODE_SCROLL: emit_report(hrb_pkg::REPORT_ID_MOUSE, 8'h00, 8'h00, wh);
      hrb_pkg::MODE_CONSPRESS: begin
        foreach (cons[i])
          if (!done && cons[i] == 16'h0000) begin
            cons[i] = code;
            done = 1;
          end
        emit_report(hrb_pkg::REPORT_ID_CONSUMER, 8'h00, 8'h00, 8'h00);
      end
      hrb_pkg::MODE_CONSRELEASE: begin
        foreach (cons[i])
          if (!done && cons[i] == code) begin
            cons[i] = 16'h0000;
            done = 1;
          end
        emit_report(hrb_pkg::REPORT_ID_CONSUMER, 8'h00, 8'h00, 8'h00);
      end
      hrb_pkg::MODE_CONSCLEAR: begin
        foreach (cons[i]) cons[i] = 16'h0000;
        emit_report(hrb_pkg::REPORT_ID_CONSUMER, 8'h00, 8'h00, 8'h00);
      end
      hrb_pkg::MODE_WAKE: link = 1'b1;
      hrb_pkg::MODE_SUSPEND: link = 1'b0;
      hrb_pkg::MODE_SETPROTO: begin
        if (code == hrb_pkg::PROTO_BOOT) boot = 1'b1;
        else if (code == hrb_pkg::PROTO_REPORT) boot = 1'b0;
      end
      hrb_pkg::MODE_LED: leds = usage;
      hrb_pkg::MODE_CONFIGURE: boot = 1'b0;
      default: ;
    endcase
  endfunction

  function void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endfunction

  function void check_byte(hid_byte_t got);
    hid_byte_t want;
    if (pending_bytes.size() == 0) begin
      $display("%0t: unexpected report byte, expected none, actual %h", $time, got);
      errors++;
      return;
    end
    want = pending_bytes.pop_front();
    checked++;
    compare_field("report_byte", want.report_byte, got.report_byte);
    compare_field("last", want.last, got.last);
    compare_field("sent_ok", want.sent_ok, got.sent_ok);
    compare_field("led_bits", want.led_bits, got.led_bits);
    compare_field("link_up", want.link_up, got.link_up);
  endfunction
endclass

module hid_report_builder_top_tb;

  localparam logic [3:0] MODE_UNUSED = 4'hF;

  logic clk;
  logic rst_n;
  bit   steady;
  bit   hold_done;

  int unsigned mode_weight [16] = '{18, 14, 4, 10, 6, 6, 6, 9, 7, 3, 5, 2, 4, 3, 2, 1};

  hrb_in_if  in_ch ();
  hrb_out_if out_ch ();

  hid_report_predictor sb;

  hid_report_builder_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #400000;
    $display("FAILED: results differ");
    $finish;
  end

  task automatic send_event(input logic [3:0] m, input logic [15:0] c,
                            input logic [7:0] x = 8'h00, input logic [7:0] y = 8'h00,
                            input logic [7:0] w = 8'h00);
    if (!steady && $urandom_range(0, 99) < 30) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= m;
    in_ch.code        <= c;
    in_ch.move_x      <= x;
    in_ch.move_y      <= y;
    in_ch.wheel_delta <= w;
    do @(posedge clk); while (!in_ch.ready);
    sb.apply_request(m, c, x, y, w);
  endtask

  // result side: random stalls plus one long hold-off to back up the input
  initial begin
    hid_byte_t got;
    @(posedge rst_n);
    forever begin
      if (!hold_done && sb.checked >= 60) begin
        out_ch.ready <= 1'b0;
        repeat (150) @(posedge clk);
        hold_done = 1;
      end
      out_ch.ready <= steady || ($urandom_range(0, 99) >= 30);
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.report_byte, out_ch.last, out_ch.sent_ok, out_ch.led_bits,
               out_ch.link_up};
        sb.check_byte(got);
      end
    end
  end

  initial begin
    logic [3:0]  m;
    logic [15:0] c;
    int unsigned r;
    int unsigned acc;
    sb = new();
    steady = 0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.mode <= '0;
    in_ch.code <= '0;
    in_ch.move_x <= '0;
    in_ch.move_y <= '0;
    in_ch.wheel_delta <= '0;
    out_ch.ready <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_event(hrb_pkg::MODE_KEYPRESS, 16'h0204);       // link down: refused, state still updated
    send_event(hrb_pkg::MODE_WAKE, 16'hFFFF);
    send_event(hrb_pkg::MODE_KEYPRESS, 16'h0105);
    send_event(hrb_pkg::MODE_KEYPRESS, 16'h0406);
    send_event(hrb_pkg::MODE_KEYPRESS, 16'h0807);
    send_event(hrb_pkg::MODE_KEYPRESS, 16'h1008);
    send_event(hrb_pkg::MODE_KEYPRESS, 16'h2009);
    send_event(hrb_pkg::MODE_KEYPRESS, 16'h80FF);       // slots full, mods still ORed
    send_event(hrb_pkg::MODE_KEYRELEASE, 16'h0033);     // absent usage
    send_event(hrb_pkg::MODE_KEYRELEASE, 16'h0205);
    send_event(hrb_pkg::MODE_KEYRELEASE, 16'h0000);     // matches the empty slot
    send_event(hrb_pkg::MODE_KEYCLEARALL, 16'h0000);
    send_event(hrb_pkg::MODE_MOVE, 16'h0000, 8'h80, 8'h7F, 8'h55);
    send_event(hrb_pkg::MODE_BTNPRESS, 16'hA5FF);
    send_event(hrb_pkg::MODE_SCROLL, 16'h0000, 8'hFF, 8'h01, 8'h80);
    send_event(hrb_pkg::MODE_CONSPRESS, 16'hFFFF);
    send_event(hrb_pkg::MODE_CONSPRESS, 16'h00E9);
    send_event(hrb_pkg::MODE_CONSPRESS, 16'h8000);
    send_event(hrb_pkg::MODE_CONSPRESS, 16'h0001);
    send_event(hrb_pkg::MODE_CONSPRESS, 16'h1234);      // consumer slots full
    send_event(hrb_pkg::MODE_CONSRELEASE, 16'hFFFF);
    send_event(hrb_pkg::MODE_SETPROTO, hrb_pkg::PROTO_BOOT);
    send_event(hrb_pkg::MODE_KEYPRESS, 16'h0104);       // boot layout, no id byte
    send_event(hrb_pkg::MODE_MOVE, 16'h0000, 8'h7F, 8'h80, 8'h00);  // refused in boot
    send_event(hrb_pkg::MODE_SETPROTO, 16'h0007);       // ignored
    send_event(hrb_pkg::MODE_CONFIGURE, 16'hBEEF);
    send_event(MODE_UNUSED, 16'h5555);
    send_event(hrb_pkg::MODE_CONSCLEAR, 16'h0000);
    send_event(hrb_pkg::MODE_SUSPEND, 16'h0000);

    for (int n = 0; n < 72; n++) begin
      steady = (n >= 30 && n < 55);
      r = $urandom_range(0, 99);
      m = 4'd0;
      acc = mode_weight[0];
      while (r >= acc) begin
        m++;
        acc += mode_weight[m];
      end
      c = 16'($urandom);
      case (m) inside
        hrb_pkg::MODE_KEYPRESS, hrb_pkg::MODE_KEYRELEASE: begin
          if ($urandom_range(0, 4) != 0) c[7:0] = 8'($urandom_range(0, 8));
        end
        hrb_pkg::MODE_CONSPRESS, hrb_pkg::MODE_CONSRELEASE: begin
          case ($urandom_range(0, 5))
            1: c = 16'h00E9;
            2: c = 16'h00EA;
            3: c = 16'h00CD;
            4: c = 16'hFFFF;
            5: c = 16'h0000;
            default: ;
          endcase
        end
        hrb_pkg::MODE_SETPROTO: begin
          case ($urandom_range(0, 4))
            0, 1: c = hrb_pkg::PROTO_BOOT;
            2, 3: c = hrb_pkg::PROTO_REPORT;
            default: ;
          endcase
        end
        default: ;
      endcase
      send_event(m, c, 8'($urandom), 8'($urandom), 8'($urandom));
    end
    steady = 0;
    in_ch.valid <= 1'b0;

    while (sb.pending_bytes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Run covered %0d events: %0d report bytes checked, %0d refused markers.",
             sb.requests, sb.checked, sb.refused);
    $display("Mismatches: %0d", sb.errors);
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
